FILE: rtl/b85_pkg.sv
// Shared types, constants and symbol mapping functions for the base-85 word codec.
// Depends on nothing; every other RTL file imports it.
`default_nettype none

package b85_pkg;

  localparam int unsigned NumChars   = 5;
  localparam int unsigned DigitW     = 7;
  localparam int unsigned QuotW      = 26;
  localparam int unsigned RecipShift = 38;

  // ceil(2^38 / 85): (v * Recip85) >> 38 equals v / 85 for every 32-bit v
  localparam logic [31:0] Recip85 = 32'd3233857729;

  localparam logic [DigitW-1:0] BadDigit = 7'd99;

  localparam logic       KindEncode = 1'b0;
  localparam logic       KindDecode = 1'b1;

  localparam logic [7:0] ChFirst  = 8'd33;   // '!'
  localparam logic [7:0] ChLast   = 8'd122;  // 'z'
  localparam logic [7:0] ChDquote = 8'd34;
  localparam logic [7:0] ChAmp    = 8'd38;
  localparam logic [7:0] ChComma  = 8'd44;
  localparam logic [7:0] ChSemi   = 8'd59;
  localparam logic [7:0] ChBslash = 8'd92;

  typedef struct packed {
    logic        kind;
    logic [31:0] word_in;
    logic [39:0] chars_in;
  } b85_in_t;

  typedef struct packed {
    logic [31:0] word_out;
    logic [39:0] chars_out;
    logic        bad_char;
  } b85_out_t;

  // Working state that travels down the pipeline.
  // dig[NumChars-1] is the most significant digit slot.
  typedef struct packed {
    logic                                kind;
    logic                                bad;
    logic [31:0]                         acc;
    logic [QuotW-1:0]                    quot;
    logic [NumChars-1:0][DigitW-1:0]     dig;
  } b85_st_t;

  function automatic logic b85_is_bad(input logic [7:0] c);
    return (c < ChFirst) || (c > ChLast) || (c == ChDquote) || (c == ChAmp) ||
           (c == ChComma) || (c == ChSemi) || (c == ChBslash);
  endfunction

  function automatic logic [DigitW-1:0] b85_digit_of(input logic [7:0] c);
    logic [7:0] d;
    d = c - ChFirst;
    if (c > ChDquote) d = d - 8'd1;
    if (c > ChAmp)    d = d - 8'd1;
    if (c > ChComma)  d = d - 8'd1;
    if (c > ChSemi)   d = d - 8'd1;
    if (c > ChBslash) d = d - 8'd1;
    if (b85_is_bad(c)) d = {1'b0, BadDigit};
    return d[DigitW-1:0];
  endfunction

  function automatic logic [7:0] b85_symbol_of(input logic [DigitW-1:0] d);
    logic [7:0] c;
    c = {1'b0, d} + ChFirst;
    if (c >= ChDquote) c = c + 8'd1;
    if (c >= ChAmp)    c = c + 8'd1;
    if (c >= ChComma)  c = c + 8'd1;
    if (c >= ChSemi)   c = c + 8'd1;
    if (c >= ChBslash) c = c + 8'd1;
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/b85_front.sv
// Entry stage: starts the first divide by 85 for encode, maps the five characters for decode.
// Depends on b85_pkg.
`default_nettype none

module b85_front
  import b85_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    up_valid,
  output logic         up_ready,
  input  wire b85_in_t up_data,
  output logic         dn_valid,
  input  wire logic    dn_ready,
  output b85_st_t      dn_data
);

  logic    valid_r, valid_nxt;
  b85_st_t st_r, st_nxt;
  logic    load;
  logic [63:0] prod;
  logic [NumChars-1:0][DigitW-1:0] dmap;
  logic [NumChars-1:0]             bmap;

  assign up_ready = !valid_r || dn_ready;
  assign load     = up_valid && up_ready;
  assign prod     = {32'd0, up_data.word_in} * {32'd0, Recip85};

  always_comb begin
    for (int k = 0; k < NumChars; k++) begin
      dmap[k] = b85_digit_of(up_data.chars_in[8*k +: 8]);
      bmap[k] = b85_is_bad(up_data.chars_in[8*k +: 8]);
    end
  end

  always_comb begin
    st_nxt      = st_r;
    valid_nxt   = valid_r;
    if (load) begin
      valid_nxt    = 1'b1;
      st_nxt.kind  = up_data.kind;
      if (up_data.kind == KindEncode) begin
        st_nxt.bad  = 1'b0;
        st_nxt.acc  = up_data.word_in;
        st_nxt.quot = prod[RecipShift +: QuotW];
        st_nxt.dig  = '0;
      end else begin
        // first character already folded into the accumulator
        st_nxt.bad  = |bmap;
        st_nxt.acc  = {{(32-DigitW){1'b0}}, dmap[NumChars-1]};
        st_nxt.quot = '0;
        st_nxt.dig  = {dmap[NumChars-2:0], {DigitW{1'b0}}};
      end
    end else if (dn_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    st_r <= st_nxt;
  end

  assign dn_valid = valid_r;
  assign dn_data  = st_r;

endmodule

`default_nettype wire

FILE: rtl/b85_mul_stage.sv
// Reciprocal multiply stage: forms the next quotient by 85 for encode, holds decode state.
// Depends on b85_pkg.
`default_nettype none

module b85_mul_stage
  import b85_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    up_valid,
  output logic         up_ready,
  input  wire b85_st_t up_data,
  output logic         dn_valid,
  input  wire logic    dn_ready,
  output b85_st_t      dn_data
);

  logic    valid_r, valid_nxt;
  b85_st_t st_r, st_nxt;
  logic    load;
  logic [63:0] prod;

  assign up_ready = !valid_r || dn_ready;
  assign load     = up_valid && up_ready;
  assign prod     = {32'd0, up_data.acc} * {32'd0, Recip85};

  always_comb begin
    st_nxt    = st_r;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
      st_nxt    = up_data;
      if (up_data.kind == KindEncode) begin
        st_nxt.quot = prod[RecipShift +: QuotW];
      end
    end else if (dn_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    st_r <= st_nxt;
  end

  assign dn_valid = valid_r;
  assign dn_data  = st_r;

endmodule

`default_nettype wire

FILE: rtl/b85_rem_stage.sv
// Remainder stage: peels one encode digit off the quotient, or does one decode v*85+digit step.
// Depends on b85_pkg.
`default_nettype none

module b85_rem_stage
  import b85_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    up_valid,
  output logic         up_ready,
  input  wire b85_st_t up_data,
  output logic         dn_valid,
  input  wire logic    dn_ready,
  output b85_st_t      dn_data
);

  logic        valid_r, valid_nxt;
  b85_st_t     st_r, st_nxt;
  logic        load;
  logic [31:0] q_ext;
  logic [31:0] q_x85;
  logic [31:0] rem;
  logic [31:0] acc_x85;

  assign up_ready = !valid_r || dn_ready;
  assign load     = up_valid && up_ready;

  assign q_ext   = {{(32-QuotW){1'b0}}, up_data.quot};
  assign q_x85   = (q_ext << 6) + (q_ext << 4) + (q_ext << 2) + q_ext;
  assign rem     = up_data.acc - q_x85;
  assign acc_x85 = (up_data.acc << 6) + (up_data.acc << 4) + (up_data.acc << 2) + up_data.acc;

  always_comb begin
    st_nxt    = st_r;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
      st_nxt    = up_data;
      if (up_data.kind == KindEncode) begin
        // new digit enters at the top; earlier (lower) digits slide down
        st_nxt.acc = q_ext;
        st_nxt.dig = {rem[DigitW-1:0], up_data.dig[NumChars-1:1]};
      end else begin
        st_nxt.acc = acc_x85 + {{(32-DigitW){1'b0}}, up_data.dig[NumChars-1]};
        st_nxt.dig = {up_data.dig[NumChars-2:0], {DigitW{1'b0}}};
      end
    end else if (dn_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    st_r <= st_nxt;
  end

  assign dn_valid = valid_r;
  assign dn_data  = st_r;

endmodule

`default_nettype wire

FILE: rtl/b85_out_stage.sv
// Output register: maps encode digits to symbols and formats the result transaction.
// Depends on b85_pkg.
`default_nettype none

module b85_out_stage
  import b85_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    up_valid,
  output logic         up_ready,
  input  wire b85_st_t up_data,
  output logic         dn_valid,
  input  wire logic    dn_ready,
  output b85_out_t     dn_data
);

  logic     valid_r, valid_nxt;
  b85_out_t res_r, res_nxt;
  logic     load;
  logic [39:0] chars;

  assign up_ready = !valid_r || dn_ready;
  assign load     = up_valid && up_ready;

  // leading digit is the final quotient (at most 82), the rest sit in dig[4:1]
  assign chars = {b85_symbol_of(up_data.acc[DigitW-1:0]),
                  b85_symbol_of(up_data.dig[4]),
                  b85_symbol_of(up_data.dig[3]),
                  b85_symbol_of(up_data.dig[2]),
                  b85_symbol_of(up_data.dig[1])};

  always_comb begin
    res_nxt   = res_r;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
      if (up_data.kind == KindEncode) begin
        res_nxt.word_out  = '0;
        res_nxt.chars_out = chars;
        res_nxt.bad_char  = 1'b0;
      end else begin
        res_nxt.word_out  = up_data.acc;
        res_nxt.chars_out = '0;
        res_nxt.bad_char  = up_data.bad;
      end
    end else if (dn_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    res_r <= res_nxt;
  end

  assign dn_valid = valid_r;
  assign dn_data  = res_r;

endmodule

`default_nettype wire

FILE: rtl/base85_word_codec.sv
// Top level of the base-85 word codec: chains the entry, divide and output stages.
// Depends on b85_pkg, b85_front, b85_mul_stage, b85_rem_stage and b85_out_stage.
//
// Usage:
//   Input channel in_valid/in_ready/in_data carries one transaction per word:
//   kind selects encode (word_in -> five characters) or decode (chars_in ->
//   word plus bad_char flag). Output channel out_valid/out_ready/out_data
//   returns exactly one result transaction per input, in order.
//   Pipeline: an accepted input transaction passes through nine register stages
//   (entry, four remainder stages, three reciprocal multiply stages, output
//   register) before out_valid rises for its result. Each divide by 85 is one
//   32x32 multiply by a fixed reciprocal followed by a shift-add remainder in
//   the next stage.
//   Throughput: one transaction per cycle, sustained, when out_ready is high.
//   Stall: when out_ready drops, results hold in the output register and the
//   stages behind it fill; in_ready drops only once every stage is occupied.
//   Nothing is lost or repeated. Empty stages still advance during a stall.
//   Reset: rst_n (synchronous, active low) clears every stage's valid bit;
//   no transaction is in flight afterwards. There is no configuration.
`default_nettype none

module base85_word_codec
  import b85_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire b85_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output b85_out_t      out_data
);

  localparam int unsigned NumMid = 7;

  // index 0 is the entry stage; 1..7 alternate remainder / multiply
  logic            st_valid [0:NumMid];
  logic            st_ready [0:NumMid];
  b85_st_t         st_data  [0:NumMid];

  b85_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_data  (in_data),
    .dn_valid (st_valid[0]),
    .dn_ready (st_ready[0]),
    .dn_data  (st_data[0])
  );

  for (genvar i = 1; i <= NumMid; i++) begin : g_mid
    if ((i % 2) == 1) begin : g_rem
      // take one digit off (encode) or fold one digit in (decode)
      b85_rem_stage u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (st_valid[i-1]),
        .up_ready (st_ready[i-1]),
        .up_data  (st_data[i-1]),
        .dn_valid (st_valid[i]),
        .dn_ready (st_ready[i]),
        .dn_data  (st_data[i])
      );
    end else begin : g_mul
      // start the next divide by 85
      b85_mul_stage u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (st_valid[i-1]),
        .up_ready (st_ready[i-1]),
        .up_data  (st_data[i-1]),
        .dn_valid (st_valid[i]),
        .dn_ready (st_ready[i]),
        .dn_data  (st_data[i])
      );
    end
  end

  b85_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (st_valid[NumMid]),
    .up_ready (st_ready[NumMid]),
    .up_data  (st_data[NumMid]),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_data  (out_data)
  );

endmodule

`default_nettype wire
